[rtl/hdh_pkg.sv]
package hdh_pkg;

  localparam int ANGLE_BITS   = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int DOT_STEPS    = 9;
  localparam int DIV_STEPS    = 16;
  localparam int GAIN_Q15     = 53961;
  localparam int DOT_W        = 35;
  localparam int CORDIC_W     = 50;
  localparam int ANG_W        = 22;
  localparam int ATAN_W       = 18;
  localparam int MASS_W       = 18;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic [ANG_W-1:0] HALF_TURN    = ANG_W'(1 << (ANGLE_BITS - 1));
  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1 << (ANGLE_BITS - 2));

  localparam logic [47:0] FRAME_S_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] FRAME_T_RESET = 48'h0000_4000_0000;
  localparam logic [47:0] FRAME_N_RESET = 48'h4000_0000_0000;
  localparam logic [5:0]  AZIMUTH_RESET = 6'd32;
  localparam logic [4:0]  POLAR_RESET   = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUNDLE_POINT = 3'd0,
    REG_FRAME_S      = 3'd1,
    REG_FRAME_T      = 3'd2,
    REG_FRAME_N      = 3'd3,
    REG_AZIMUTH_BINS = 3'd4,
    REG_POLAR_BINS   = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DOT, S_CHECK, S_GAIN, S_PHI, S_TINIT, S_THETA,
    S_BIN, S_INDEX, S_URD, S_UWR, S_RIDX, S_RRD, S_DINIT, S_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic dot;
    logic gain;
    logic cordic;
    logic theta_init;
    logic bin;
    logic index;
    logic mem_rd;
    logic upd_wr;
    logic rd_index;
    logic div_init;
    logic div_step;
    logic out_load;
  } hdh_cmd_t;

  typedef struct packed {
    logic in_read;
    logic drop;
    logic out_full;
  } hdh_status_t;

  function automatic logic [ATAN_W-1:0] atan_entry(input logic [3:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      4'd0:    v = 18'd131072;
      4'd1:    v = 18'd77376;
      4'd2:    v = 18'd40884;
      4'd3:    v = 18'd20753;
      4'd4:    v = 18'd10417;
      4'd5:    v = 18'd5213;
      4'd6:    v = 18'd2607;
      4'd7:    v = 18'd1304;
      4'd8:    v = 18'd652;
      4'd9:    v = 18'd326;
      4'd10:   v = 18'd163;
      4'd11:   v = 18'd81;
      4'd12:   v = 18'd41;
      4'd13:   v = 18'd20;
      4'd14:   v = 18'd10;
      default: v = 18'd5;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/hdh_ifs.sv]
interface hdh_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] source_x;
  logic [15:0] source_y;
  logic [15:0] source_z;
  logic [15:0] power_red;
  logic [15:0] power_green;
  logic [15:0] power_blue;
  logic [8:0]  read_index;
  modport source (output valid, action, source_x, source_y, source_z, power_red,
                  power_green, power_blue, read_index, input ready);
  modport sink (input valid, action, source_x, source_y, source_z, power_red,
                power_green, power_blue, read_index, output ready);
endinterface

interface hdh_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  bin_number;
  logic [31:0] bin_total;
  logic [15:0] bin_share;
  modport source (output valid, bin_number, bin_total, bin_share, input ready);
  modport sink (input valid, bin_number, bin_total, bin_share, output ready);
endinterface

interface hdh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/hdh_datapath.sv]
module hdh_datapath #(
  parameter int MAX_AZIMUTH_BINS = 32,
  parameter int MAX_POLAR_BINS   = 16,
  parameter int CNT_W            = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hdh_pkg::hdh_cmd_t   cmd,
  output hdh_pkg::hdh_status_t status,
  input  logic [CNT_W-1:0]    cnt,
  input  logic                in_action,
  input  logic [15:0]         in_source_x,
  input  logic [15:0]         in_source_y,
  input  logic [15:0]         in_source_z,
  input  logic [15:0]         in_power_red,
  input  logic [15:0]         in_power_green,
  input  logic [15:0]         in_power_blue,
  input  logic [8:0]          in_read_index,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [8:0]          out_bin_number,
  output logic [31:0]         out_bin_total,
  output logic [15:0]         out_bin_share
);
  import hdh_pkg::*;

  localparam int DEPTH  = MAX_AZIMUTH_BINS * MAX_POLAR_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AZ_W   = $clog2(MAX_AZIMUTH_BINS + 1);
  localparam int PO_W   = $clog2(MAX_POLAR_BINS + 1);

  logic [47:0] bp_r, fs_r, ft_r, fn_r;
  logic [5:0]  az_r;
  logic [4:0]  po_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0;
      fs_r <= FRAME_S_RESET;
      ft_r <= FRAME_T_RESET;
      fn_r <= FRAME_N_RESET;
      az_r <= AZIMUTH_RESET;
      po_r <= POLAR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUNDLE_POINT: bp_r <= cfg_data;
        REG_FRAME_S:      fs_r <= cfg_data;
        REG_FRAME_T:      ft_r <= cfg_data;
        REG_FRAME_N:      fn_r <= cfg_data;
        REG_AZIMUTH_BINS: az_r <= cfg_data[5:0];
        REG_POLAR_BINS:   po_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [AZ_W-1:0] az_c;
  logic [PO_W-1:0] po_c;

  always_comb begin
    if (az_r == '0) az_c = AZ_W'(1);
    else if (int'(az_r) > MAX_AZIMUTH_BINS) az_c = AZ_W'(MAX_AZIMUTH_BINS);
    else az_c = AZ_W'(az_r);
    if (po_r == '0) po_c = PO_W'(1);
    else if (int'(po_r) > MAX_POLAR_BINS) po_c = PO_W'(MAX_POLAR_BINS);
    else po_c = PO_W'(po_r);
  end

  logic signed [16:0]       d_r [3];
  logic [MASS_W-1:0]        mass_r;
  logic [8:0]               idx_r;
  logic signed [DOT_W-1:0]  acc_r [3];

  logic [1:0]          axis_sel, comp_sel;
  logic [47:0]         axis_vec;
  logic signed [15:0]  coef_s;
  logic signed [16:0]  dsel_s;
  logic signed [32:0]  prod;

  always_comb begin
    unique case (cnt[3:0])
      4'd0:    begin axis_sel = 2'd0; comp_sel = 2'd0; end
      4'd1:    begin axis_sel = 2'd0; comp_sel = 2'd1; end
      4'd2:    begin axis_sel = 2'd0; comp_sel = 2'd2; end
      4'd3:    begin axis_sel = 2'd1; comp_sel = 2'd0; end
      4'd4:    begin axis_sel = 2'd1; comp_sel = 2'd1; end
      4'd5:    begin axis_sel = 2'd1; comp_sel = 2'd2; end
      4'd6:    begin axis_sel = 2'd2; comp_sel = 2'd0; end
      4'd7:    begin axis_sel = 2'd2; comp_sel = 2'd1; end
      default: begin axis_sel = 2'd2; comp_sel = 2'd2; end
    endcase
    unique case (axis_sel)
      2'd0:    axis_vec = fs_r;
      2'd1:    axis_vec = ft_r;
      default: axis_vec = fn_r;
    endcase
    unique case (comp_sel)
      2'd0:    begin coef_s = $signed(axis_vec[15:0]);  dsel_s = d_r[0]; end
      2'd1:    begin coef_s = $signed(axis_vec[31:16]); dsel_s = d_r[1]; end
      default: begin coef_s = $signed(axis_vec[47:32]); dsel_s = d_r[2]; end
    endcase
    prod = coef_s * dsel_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r[0] <= $signed({in_source_x[15], in_source_x}) - $signed({bp_r[15], bp_r[15:0]});
      d_r[1] <= $signed({in_source_y[15], in_source_y}) - $signed({bp_r[31], bp_r[31:16]});
      d_r[2] <= $signed({in_source_z[15], in_source_z}) - $signed({bp_r[47], bp_r[47:32]});
      mass_r <= MASS_W'(in_power_red) + MASS_W'(in_power_green) + MASS_W'(in_power_blue);
      idx_r  <= in_read_index;
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
    end else if (cmd.dot) begin
      acc_r[axis_sel] <= acc_r[axis_sel] + DOT_W'(prod);
    end
  end

  logic signed [CORDIC_W-1:0] cx_r, cy_r, up_r;
  logic signed [ANG_W-1:0]    ang_r;
  logic [ANGLE_BITS-1:0]      phi_r;
  logic signed [CORDIC_W-1:0] lx_s, lz_s, dx, dy;
  logic signed [ANG_W-1:0]    atan_s;
  logic signed [51:0]         up_prod;
  logic signed [16:0]         gain_s;

  always_comb begin
    lx_s    = CORDIC_W'(acc_r[0]) <<< 8;
    lz_s    = CORDIC_W'(acc_r[2]) <<< 8;
    dx      = cy_r >>> cnt[3:0];
    dy      = cx_r >>> cnt[3:0];
    atan_s  = $signed(ANG_W'(atan_entry(cnt[3:0])));
    gain_s  = $signed(17'(GAIN_Q15));
    up_prod = acc_r[1] * gain_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      up_r <= CORDIC_W'(up_prod >>> 7);
      if (lx_s < 0) begin
        cx_r  <= -lx_s;
        cy_r  <= -lz_s;
        ang_r <= $signed(HALF_TURN);
      end else begin
        cx_r  <= lx_s;
        cy_r  <= lz_s;
        ang_r <= '0;
      end
    end else if (cmd.theta_init) begin
      phi_r <= ang_r[ANGLE_BITS-1:0];
      cx_r  <= up_r;
      cy_r  <= cx_r;
      ang_r <= '0;
    end else if (cmd.cordic) begin
      if (!cy_r[CORDIC_W-1]) begin
        cx_r  <= cx_r + dx;
        cy_r  <= cy_r - dy;
        ang_r <= ang_r + atan_s;
      end else begin
        cx_r  <= cx_r - dx;
        cy_r  <= cy_r + dy;
        ang_r <= ang_r - atan_s;
      end
    end
  end

  logic [ANGLE_BITS-2:0]      theta;
  logic [ANGLE_BITS+AZ_W-1:0] pb_full;
  logic [ANGLE_BITS+PO_W-2:0] tb_full;
  logic [AZ_W-1:0]            pb, pb_r;
  logic [PO_W:0]              tb;
  logic [PO_W-1:0]            tb_r;
  logic [ADDR_W-1:0]          addr_r;

  always_comb begin
    if (ang_r < 0) theta = '0;
    else if (ang_r > $signed(QUARTER_TURN)) theta = QUARTER_TURN[ANGLE_BITS-2:0];
    else theta = ang_r[ANGLE_BITS-2:0];
    pb_full = (ANGLE_BITS + AZ_W)'(phi_r) * (ANGLE_BITS + AZ_W)'(az_c);
    tb_full = (ANGLE_BITS + PO_W - 1)'(theta) * (ANGLE_BITS + PO_W - 1)'(po_c);
    pb = pb_full[ANGLE_BITS+AZ_W-1:ANGLE_BITS];
    tb = tb_full[ANGLE_BITS+PO_W-2:ANGLE_BITS-2];
  end

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r, sum_r, mass_out_r;
  logic        in_range_r;

  always_ff @(posedge clk) begin
    if (cmd.bin) begin
      pb_r <= (pb >= az_c) ? az_c - AZ_W'(1) : pb;
      tb_r <= (tb >= (PO_W + 1)'(po_c)) ? po_c - PO_W'(1) : tb[PO_W-1:0];
    end
    if (cmd.index) begin
      addr_r <= ADDR_W'(32'(tb_r) * 32'(az_c) + 32'(pb_r));
    end else if (cmd.rd_index) begin
      addr_r     <= ADDR_W'(idx_r);
      in_range_r <= (32'(idx_r) < 32'(az_c) * 32'(po_c)) && (32'(idx_r) < DEPTH);
    end
    if (cmd.mem_rd) rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) mem[cnt[ADDR_W-1:0]] <= '0;
    else if (cmd.upd_wr) mem[addr_r] <= sat_add32(rdata_r, 32'(mass_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sum_r <= '0;
    else if (cmd.upd_wr) sum_r <= sat_add32(sum_r, 32'(mass_r));
  end

  logic [31:0] massq, rem_r;
  logic [32:0] rem_sh;
  logic [15:0] q_r;
  logic        q16_r;

  always_comb begin
    massq  = in_range_r ? rdata_r : '0;
    rem_sh = {rem_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      mass_out_r <= massq;
      q_r        <= '0;
      q16_r      <= (massq >= sum_r);
      rem_r      <= (massq >= sum_r) ? massq - sum_r : massq;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, sum_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, sum_r});
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin_number <= idx_r;
      out_bin_total  <= mass_out_r;
      out_bin_share  <= (sum_r == '0) ? 16'd0 : (q16_r ? 16'hFFFF : q_r);
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    status.in_read  = in_action;
    status.drop     = ((acc_r[0] == '0) && (acc_r[1] == '0) && (acc_r[2] == '0)) ||
                      (acc_r[1] < 0);
    status.out_full = out_valid_r && !out_ready;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result word overwritten while held");

  a_sum_monotonic: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> sum_r >= $past(sum_r))
    else $error("mass total decreased");

  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> $past(cmd.mem_rd))
    else $error("bin update without prior read");

endmodule

[rtl/hdh_ctrl.sv]
module hdh_ctrl #(
  parameter int MAX_AZIMUTH_BINS = 32,
  parameter int MAX_POLAR_BINS   = 16,
  parameter int CNT_W            = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hdh_pkg::hdh_status_t status,
  output hdh_pkg::hdh_cmd_t    cmd,
  output logic [CNT_W-1:0]     cnt
);
  import hdh_pkg::*;

  localparam int DEPTH = MAX_AZIMUTH_BINS * MAX_POLAR_BINS;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (cnt_r == CNT_W'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_read ? S_RIDX : S_DOT;
        end
      end
      S_DOT: begin
        cmd.dot = 1'b1;
        if (cnt_r == CNT_W'(DOT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_CHECK: state_nxt = status.drop ? S_IDLE : S_GAIN;
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.cordic = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_TINIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_TINIT: begin
        cmd.theta_init = 1'b1;
        state_nxt      = S_THETA;
      end
      S_THETA: begin
        cmd.cordic = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_BIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = S_INDEX;
      end
      S_INDEX: begin
        cmd.index = 1'b1;
        state_nxt = S_URD;
      end
      S_URD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RIDX: begin
        cmd.rd_index = 1'b1;
        state_nxt    = S_RRD;
      end
      S_RRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cnt = cnt_r;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted word not processed");

  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TINIT |-> $past(state_r) == S_PHI && $past(cnt_r) == CNT_W'(CORDIC_STEPS - 1))
    else $error("azimuth CORDIC cut short");

endmodule

[rtl/hemisphere_direction_histogram_unit.sv]
// Splat word: 9 dot-product steps on one shared 16x17 multiplier; unless dropped (zero
//   vector or negative T term), two 16-step CORDIC passes, bin mapping, memory read/write.
// Read word: memory read, 16-step share division, output register.
// One word in flight at a time; the next is accepted once the current one is finished.
// Reset: synchronous active-low; a clearing pass over all bins (one bin per cycle) zeroes
//   the bin store before the first word is accepted; configuration writes are always taken.
module hemisphere_direction_histogram_unit #(
  parameter int MAX_AZIMUTH_BINS = 32,
  parameter int MAX_POLAR_BINS   = 16
) (
  input logic      clk,
  input logic      rst_n,
  hdh_in_if.sink   in_ch,
  hdh_out_if.source out_ch,
  hdh_cfg_if.sink  cfg_ch
);
  import hdh_pkg::*;

  localparam int DEPTH  = MAX_AZIMUTH_BINS * MAX_POLAR_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = (ADDR_W > 4) ? ADDR_W : 4;

  hdh_cmd_t         cmd;
  hdh_status_t      status;
  logic [CNT_W-1:0] cnt;
  logic             in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  hdh_ctrl #(
    .MAX_AZIMUTH_BINS(MAX_AZIMUTH_BINS),
    .MAX_POLAR_BINS  (MAX_POLAR_BINS),
    .CNT_W           (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd),
    .cnt     (cnt)
  );

  hdh_datapath #(
    .MAX_AZIMUTH_BINS(MAX_AZIMUTH_BINS),
    .MAX_POLAR_BINS  (MAX_POLAR_BINS),
    .CNT_W           (CNT_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cnt           (cnt),
    .in_action     (in_ch.action),
    .in_source_x   (in_ch.source_x),
    .in_source_y   (in_ch.source_y),
    .in_source_z   (in_ch.source_z),
    .in_power_red  (in_ch.power_red),
    .in_power_green(in_ch.power_green),
    .in_power_blue (in_ch.power_blue),
    .in_read_index (in_ch.read_index),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_bin_number(out_ch.bin_number),
    .out_bin_total (out_ch.bin_total),
    .out_bin_share (out_ch.bin_share)
  );

endmodule

[tb/hemisphere_direction_histogram_unit_test.sv]
`timescale 1ns / 1ps

module hemisphere_direction_histogram_unit_test;
  import hdh_pkg::*;

  localparam int MAX_A       = 32;
  localparam int MAX_T       = 16;
  localparam int STORE_WORDS = MAX_A * MAX_T;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 80;
  localparam int ACT_SPLAT   = 0;
  localparam int ACT_READ    = 1;
  localparam longint ATAN_STEP [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                        1304, 652, 326, 163, 81, 41, 20, 10, 5};

  typedef struct {
    bit          action;
    logic [15:0] sx, sy, sz;
    logic [15:0] pr, pg, pb;
    logic [8:0]  idx;
  } photon_word_t;

  typedef struct {
    logic [8:0]  bin_number;
    logic [31:0] bin_total;
    logic [15:0] bin_share;
  } bin_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdh_in_if  in_ch();
  hdh_out_if out_ch();
  hdh_cfg_if cfg_ch();

  hemisphere_direction_histogram_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  photon_word_t word_queue[$];
  bin_reading_t bin_reading_q[$];

  logic [47:0] m_bundle, m_s_axis, m_t_axis, m_n_axis;
  logic [5:0]  m_azimuth;
  logic [4:0]  m_polar;
  logic [31:0] m_bin_mass [STORE_WORDS];
  logic [31:0] m_mass_sum;

  int  errors = 0;
  int  splats_seen = 0;
  int  reads_seen = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  holdoff = 0;
  bit  holdoff_req = 0;
  bit  quiet = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic longint lane(input logic [47:0] v, input int k);
    logic signed [15:0] s;
    s = v[16*k +: 16];
    return longint'(s);
  endfunction

  function automatic longint cordic_vec(inout longint x, input longint y, input longint base);
    longint ang, dx, dy;
    ang = base;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ATAN_STEP[i];
      end else begin
        x -= dx; y += dy; ang -= ATAN_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic longint clamp_bins(input longint v, input longint mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic longint axis_dot(input logic [47:0] ax, input longint d [3]);
    return lane(ax, 0) * d[0] + lane(ax, 1) * d[1] + lane(ax, 2) * d[2];
  endfunction

  task automatic accumulate_photon(input photon_word_t w);
    longint d [3];
    longint lx, ly, lz, mag, up, phi, theta, a, t, pbin, tbin;
    logic signed [15:0] src [3];
    logic [31:0] mass;
    int k;
    a = clamp_bins(m_azimuth, MAX_A);
    t = clamp_bins(m_polar, MAX_T);
    src[0] = w.sx; src[1] = w.sy; src[2] = w.sz;
    for (int i = 0; i < 3; i++) d[i] = longint'(src[i]) - lane(m_bundle, i);
    lx = axis_dot(m_s_axis, d) * 256;
    ly = axis_dot(m_t_axis, d) * 256;
    lz = axis_dot(m_n_axis, d) * 256;
    if (lx == 0 && ly == 0 && lz == 0) return;
    if (ly < 0) return;
    if (lx < 0) begin
      mag = -lx;
      phi = cordic_vec(mag, -lz, longint'(1) << 19);
    end else begin
      mag = lx;
      phi = cordic_vec(mag, lz, 0);
    end
    phi = phi & ((longint'(1) << 20) - 1);
    up = (ly * 53961) >>> 15;
    theta = cordic_vec(up, mag, 0);
    if (theta < 0) theta = 0;
    if (theta > (longint'(1) << 18)) theta = longint'(1) << 18;
    pbin = (phi * a) >>> 20;
    if (pbin >= a) pbin = a - 1;
    tbin = (theta * t) >>> 18;
    if (tbin >= t) tbin = t - 1;
    mass = 32'(w.pr) + 32'(w.pg) + 32'(w.pb);
    k = int'(tbin * a + pbin);
    if (k < STORE_WORDS) m_bin_mass[k] = add_sat(m_bin_mass[k], mass);
    m_mass_sum = add_sat(m_mass_sum, mass);
  endtask

  function automatic bin_reading_t read_bin(input logic [8:0] idx);
    bin_reading_t r;
    longint a, t, mass, share;
    a = clamp_bins(m_azimuth, MAX_A);
    t = clamp_bins(m_polar, MAX_T);
    mass = 0;
    share = 0;
    if (idx < a * t) mass = m_bin_mass[idx];
    if (m_mass_sum != 0) begin
      share = (mass << 16) / longint'(m_mass_sum);
      if (share > 65535) share = 65535;
    end
    r.bin_number = idx;
    r.bin_total = mass[31:0];
    r.bin_share = share[15:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_READ) begin
          bin_reading_q.push_back(read_bin(in_ch.read_index));
          reads_seen++;
        end else begin
          accumulate_photon('{in_ch.action, in_ch.source_x, in_ch.source_y, in_ch.source_z,
                              in_ch.power_red, in_ch.power_green, in_ch.power_blue,
                              in_ch.read_index});
          splats_seen++;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 14);
          in_ch.valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          photon_word_t w;
          w = word_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.action      <= w.action;
          in_ch.source_x    <= w.sx;
          in_ch.source_y    <= w.sy;
          in_ch.source_z    <= w.sz;
          in_ch.power_red   <= w.pr;
          in_ch.power_green <= w.pg;
          in_ch.power_blue  <= w.pb;
          in_ch.read_index  <= w.idx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (bin_reading_q.size() == 0) begin
          report("unexpected word", out_ch.bin_number, 0);
        end else begin
          bin_reading_t e;
          e = bin_reading_q.pop_front();
          if (out_ch.bin_number !== e.bin_number)
            report("bin_number", out_ch.bin_number, e.bin_number);
          if (out_ch.bin_total !== e.bin_total)
            report("bin_total", out_ch.bin_total, e.bin_total);
          if (out_ch.bin_share !== e.bin_share)
            report("bin_share", out_ch.bin_share, e.bin_share);
        end
      end
      if (holdoff_req && holdoff == 0) begin
        holdoff <= 400;
        holdoff_req <= 1'b0;
        out_ch.ready <= 1'b0;
      end else if (holdoff > 0) begin
        holdoff <= holdoff - 1;
        out_ch.ready <= (holdoff == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= (recv_gap == 1);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_BUNDLE_POINT: m_bundle  = data;
      REG_FRAME_S:      m_s_axis  = data;
      REG_FRAME_T:      m_t_axis  = data;
      REG_FRAME_N:      m_n_axis  = data;
      REG_AZIMUTH_BINS: m_azimuth = data[5:0];
      REG_POLAR_BINS:   m_polar   = data[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (word_queue.size() != 0 || in_ch.valid || bin_reading_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic photon_word_t splat_word(input logic [15:0] x, input logic [15:0] y,
                                              input logic [15:0] z, input logic [15:0] r,
                                              input logic [15:0] g, input logic [15:0] b);
    photon_word_t w;
    w = '{ACT_SPLAT, x, y, z, r, g, b, 9'($urandom)};
    return w;
  endfunction

  function automatic photon_word_t read_word(input logic [8:0] idx);
    photon_word_t w;
    w = '{ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), 16'($urandom), idx};
    return w;
  endfunction

  function automatic photon_word_t random_word();
    longint at;
    logic [15:0] y;
    at = clamp_bins(m_azimuth, MAX_A) * clamp_bins(m_polar, MAX_T);
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 3) == 0) return read_word(9'($urandom));
      return read_word(9'($urandom_range(0, int'(at) - 1)));
    end
    y = 16'($urandom);
    if ($urandom_range(0, 3) != 0) y = 16'($urandom_range(0, 32767));
    return splat_word(16'($urandom), y, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
  endfunction

  function automatic logic [47:0] random_axis();
    logic [47:0] v;
    case ($urandom_range(0, 3))
      0: v = 48'($urandom) | (48'($urandom) << 32);
      1: v = {16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
              16'($urandom_range(0, 32767) - 16384)};
      2: v = {3{16'h7FFF}};
      default: v = {3{16'h8000}};
    endcase
    return v;
  endfunction

  initial begin
    in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.read_index = '0;
    in_ch.source_x = '0; in_ch.source_y = '0; in_ch.source_z = '0;
    in_ch.power_red = '0; in_ch.power_green = '0; in_ch.power_blue = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_BUNDLE_POINT; cfg_ch.data = '0;
  end

  initial begin
    m_bundle = '0;
    m_s_axis = FRAME_S_RESET; m_t_axis = FRAME_T_RESET; m_n_axis = FRAME_N_RESET;
    m_azimuth = AZIMUTH_RESET; m_polar = POLAR_RESET;
    m_mass_sum = '0;
    foreach (m_bin_mass[i]) m_bin_mass[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    word_queue.push_back(read_word(9'd0));
    word_queue.push_back(splat_word(16'd0, 16'd100, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    word_queue.push_back(splat_word(16'd0, 16'd0, 16'd0, 16'd500, 16'd1, 16'd2));
    word_queue.push_back(splat_word(16'd3, 16'hFFFB, 16'd7, 16'd9, 16'd9, 16'd9));
    word_queue.push_back(splat_word(16'd100, 16'd0, 16'd0, 16'd10, 16'd20, 16'd30));
    word_queue.push_back(splat_word(16'hFF9C, 16'd50, 16'hFFE2, 16'd1000, 16'd0, 16'd0));
    word_queue.push_back(splat_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0));
    word_queue.push_back(splat_word(16'h8000, 16'h7FFF, 16'h8000, 16'd1, 16'd0, 16'd0));
    word_queue.push_back(splat_word(16'd0, 16'd1, 16'h8000, 16'd77, 16'd88, 16'd99));
    word_queue.push_back(splat_word(16'h8000, 16'd1, 16'd0, 16'd5, 16'd6, 16'd7));
    for (int i = 0; i < 6; i++) word_queue.push_back(read_word(9'($urandom_range(0, 511))));
    word_queue.push_back(read_word(9'd511));
    word_queue.push_back(read_word(9'd15 * 9'd32));
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_AZIMUTH_BINS, 48'd0);
          write_reg(REG_POLAR_BINS, 48'd0);
        end
        1: begin
          write_reg(REG_AZIMUTH_BINS, 48'd63);
          write_reg(REG_POLAR_BINS, 48'd31);
          write_reg(REG_BUNDLE_POINT, {16'h8000, 16'h7FFF, 16'h8000});
        end
        5: begin
          write_reg(REG_BUNDLE_POINT, 48'd0);
          write_reg(REG_FRAME_S, FRAME_S_RESET);
          write_reg(REG_FRAME_T, FRAME_T_RESET);
          write_reg(REG_FRAME_N, FRAME_N_RESET);
          write_reg(REG_AZIMUTH_BINS, 48'($urandom_range(1, 32)));
          write_reg(REG_POLAR_BINS, 48'($urandom_range(1, 16)));
          quiet = 1;
        end
        default: begin
          write_reg(REG_BUNDLE_POINT, 48'($urandom) | (48'($urandom) << 32));
          write_reg(REG_FRAME_S, random_axis());
          write_reg(REG_FRAME_T, random_axis());
          write_reg(REG_FRAME_N, random_axis());
          write_reg(REG_AZIMUTH_BINS, 48'($urandom_range(1, 32)));
          write_reg(REG_POLAR_BINS, 48'($urandom_range(1, 16)));
        end
      endcase
      for (int i = 0; i < 100; i++) word_queue.push_back(random_word());
      if (p == 2) holdoff_req = 1;
      drain();
    end

    $display("covered %0d splat words and %0d read words over 7 settings", splats_seen,
             reads_seen);
    $display("bin counts from clamped-low to clamped-high, with random frames and offsets");
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
